[sv/mqmb_pkg.sv]
// Shared types and constants for the multi-queue message mailbox.
// Holds the command and status codes, the queue pointer entry and the step result.
// Depends on nothing; every other file of the block but mqmb_ram imports it.
package mqmb_pkg;

  localparam int PTR_W     = 6;
  localparam int WORD_W    = 64;
  localparam int MSG_WORDS = 7;
  localparam int MSG_W     = MSG_WORDS * WORD_W;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_INIT  = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
    logic [PTR_W-1:0] mask;
  } qstate_t;

  localparam int QSTATE_W = $bits(qstate_t);

  typedef struct packed {
    qstate_t    next;
    logic       wr_en;
    logic       push_ok;
    logic       pop_ok;
    logic [1:0] status;
    logic       is_empty;
    logic       wake;
  } step_t;

  function automatic logic [PTR_W-1:0] depth_mask(input int depth);
    return PTR_W'((depth - 1) & ((1 << PTR_W) - 1));
  endfunction

endpackage

[sv/mqmb_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Used for the queue pointer table and for the message store.
// Depends on nothing.
module mqmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/mqmb_step.sv]
// Pointer update for one mailbox command on one queue entry.
// Decides fullness, emptiness, status and wake, and forms the entry to write back.
// Depends on mqmb_pkg.
module mqmb_step import mqmb_pkg::*; #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic             [1:0] command,
  input  logic                   queue_ok,
  input  qstate_t                cur,
  input  logic [PTR_W-1:0]       new_mask,
  input  logic                   dest_waiting,
  output step_t                  res
);

  localparam logic [PTR_W-1:0] DEPTH_MASK = depth_mask(QUEUE_DEPTH);

  logic [PTR_W-1:0] tail_inc;
  logic [PTR_W-1:0] head_inc;

  assign tail_inc = (cur.tail + PTR_W'(1)) & cur.mask;
  assign head_inc = (cur.head + PTR_W'(1)) & cur.mask;

  always_comb begin
    res          = '0;
    res.next     = cur;
    res.status   = STAT_OK;
    res.is_empty = 1'b1;
    if (!queue_ok) begin
      unique case (command)
        CMD_PUSH: res.status = STAT_FULL;
        CMD_POP:  res.status = STAT_EMPTY;
        default:  res.status = STAT_OK;
      endcase
    end else begin
      unique case (command)
        CMD_PUSH: begin
          if (tail_inc == cur.head) begin
            res.status = STAT_FULL;
          end else begin
            res.next.tail = tail_inc;
            res.wr_en     = 1'b1;
            res.push_ok   = 1'b1;
            res.wake      = dest_waiting;
          end
        end
        CMD_POP: begin
          if (cur.head == cur.tail) begin
            res.status = STAT_EMPTY;
          end else begin
            res.next.head = head_inc;
            res.wr_en     = 1'b1;
            res.pop_ok    = 1'b1;
          end
        end
        CMD_INIT: begin
          res.next.head = '0;
          res.next.tail = '0;
          res.next.mask = new_mask & DEPTH_MASK;
          res.wr_en     = 1'b1;
        end
        default: ;
      endcase
      res.is_empty = (res.next.head == res.next.tail);
    end
  end

endmodule

[sv/multi_queue_message_mailbox_unit.sv]
// Top level of the multi-queue message mailbox: control, pointer table and message store.
// Depends on mqmb_pkg, mqmb_ram and mqmb_step.
//
// A command is taken when start is high and busy is low. The cycle after it reads the
// queue's pointer entry, writes the updated entry back and writes or reads the message
// store, with busy high. The result appears on the following cycle with done high for
// exactly that one cycle, and the receiver cannot stall it, so it must capture the word
// then. A new command may be started in the done cycle; while busy is high none is taken,
// as the read-modify-write of the pointer table is under way. Pointer entries read their
// reset value until first written; the message store is not cleared, and no reset pass
// is needed.
module multi_queue_message_mailbox_unit import mqmb_pkg::*; #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  input  logic [1:0]        command,
  input  logic [2:0]        queue_id,
  input  logic [WORD_W-1:0] arg_word0,
  input  logic [WORD_W-1:0] arg_word1,
  input  logic [WORD_W-1:0] arg_word2,
  input  logic [WORD_W-1:0] arg_word3,
  input  logic [WORD_W-1:0] ret_word0,
  input  logic [WORD_W-1:0] ret_word1,
  input  logic [WORD_W-1:0] sync_value,
  input  logic [PTR_W-1:0]  new_mask,
  input  logic              dest_waiting,
  output logic [1:0]        status,
  output logic [WORD_W-1:0] out_arg0,
  output logic [WORD_W-1:0] out_arg1,
  output logic [WORD_W-1:0] out_arg2,
  output logic [WORD_W-1:0] out_arg3,
  output logic [WORD_W-1:0] out_ret0,
  output logic [WORD_W-1:0] out_ret1,
  output logic [WORD_W-1:0] out_sync,
  output logic              queue_is_empty,
  output logic              wake
);

  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_STEP = 1'b1;

  localparam qstate_t RESET_ENTRY = '{head: '0, tail: '0, mask: depth_mask(QUEUE_DEPTH)};

  logic                  state;
  logic                  accept;
  logic [QIDX_W-1:0]     qidx_in;
  logic                  queue_ok_in;
  logic [NUM_QUEUES-1:0] qvalid;

  logic [1:0]            cmd_r;
  logic [QIDX_W-1:0]     qidx_r;
  logic                  queue_ok_r;
  logic                  entry_valid_r;
  logic [PTR_W-1:0]      new_mask_r;
  logic                  dest_waiting_r;
  logic [MSG_W-1:0]      msg_r;
  logic                  pop_ok_r;

  logic [QSTATE_W-1:0]   ptr_rdata;
  qstate_t               cur;
  step_t                 res;
  logic                  step;
  logic [SA_W-1:0]       push_addr;
  logic [SA_W-1:0]       pop_addr;
  logic [MSG_W-1:0]      store_rdata;
  logic [MSG_W-1:0]      msg_out;

  function automatic logic [SA_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
                                                input logic [PTR_W-1:0]  p);
    logic [SA_W-1:0] base;
    base = SA_W'(q) * SA_W'(QUEUE_DEPTH);
    return base + SA_W'(p);
  endfunction

  assign busy        = (state == ST_STEP);
  assign step        = (state == ST_STEP);
  assign accept      = start && !busy;
  assign qidx_in     = QIDX_W'(queue_id);
  assign queue_ok_in = (int'(queue_id) < NUM_QUEUES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      done   <= 1'b0;
      qvalid <= '0;
    end else begin
      done <= step;
      if (accept) begin
        state <= ST_STEP;
      end else if (step) begin
        state <= ST_IDLE;
      end
      if (step && res.wr_en) begin
        qvalid[qidx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r          <= command;
      qidx_r         <= qidx_in;
      queue_ok_r     <= queue_ok_in;
      entry_valid_r  <= queue_ok_in && qvalid[qidx_in];
      new_mask_r     <= new_mask;
      dest_waiting_r <= dest_waiting;
      msg_r          <= {arg_word0, arg_word1, arg_word2, arg_word3,
                         ret_word0, ret_word1, sync_value};
    end
    if (step) begin
      status         <= res.status;
      queue_is_empty <= res.is_empty;
      wake           <= res.wake;
      pop_ok_r       <= res.pop_ok;
    end
  end

  mqmb_ram #(
    .WIDTH (QSTATE_W),
    .DEPTH (NUM_QUEUES)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (step && res.wr_en),
    .waddr (qidx_r),
    .wdata (res.next),
    .re    (accept),
    .raddr (qidx_in),
    .rdata (ptr_rdata)
  );

  assign cur = entry_valid_r ? qstate_t'(ptr_rdata) : RESET_ENTRY;

  mqmb_step #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_step (
    .command      (cmd_r),
    .queue_ok     (queue_ok_r),
    .cur          (cur),
    .new_mask     (new_mask_r),
    .dest_waiting (dest_waiting_r),
    .res          (res)
  );

  assign push_addr = slot_addr(qidx_r, cur.tail);
  assign pop_addr  = slot_addr(qidx_r, cur.head);

  mqmb_ram #(
    .WIDTH (MSG_W),
    .DEPTH (SLOTS)
  ) u_msg_ram (
    .clk   (clk),
    .we    (step && res.push_ok),
    .waddr (push_addr),
    .wdata (msg_r),
    .re    (step && res.pop_ok),
    .raddr (pop_addr),
    .rdata (store_rdata)
  );

  assign msg_out  = pop_ok_r ? store_rdata : '0;
  assign out_arg0 = msg_out[7*WORD_W-1:6*WORD_W];
  assign out_arg1 = msg_out[6*WORD_W-1:5*WORD_W];
  assign out_arg2 = msg_out[5*WORD_W-1:4*WORD_W];
  assign out_arg3 = msg_out[4*WORD_W-1:3*WORD_W];
  assign out_ret0 = msg_out[3*WORD_W-1:2*WORD_W];
  assign out_ret1 = msg_out[2*WORD_W-1:WORD_W];
  assign out_sync = msg_out[WORD_W-1:0];

endmodule

[sim/mqmb_mailbox_checker.sv]
// Checker for the multi-queue message mailbox: predicts each command's result and compares it.
// Depends on mqmb_pkg; watches the start/busy/done channel and the payload ports of the unit.
// Hands the mismatch count and the number of outstanding results to the testbench top.
module mqmb_mailbox_checker import mqmb_pkg::*; #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              done,
  input  logic [1:0]        command,
  input  logic [2:0]        queue_id,
  input  logic [WORD_W-1:0] arg_word0,
  input  logic [WORD_W-1:0] arg_word1,
  input  logic [WORD_W-1:0] arg_word2,
  input  logic [WORD_W-1:0] arg_word3,
  input  logic [WORD_W-1:0] ret_word0,
  input  logic [WORD_W-1:0] ret_word1,
  input  logic [WORD_W-1:0] sync_value,
  input  logic [PTR_W-1:0]  new_mask,
  input  logic              dest_waiting,
  input  logic [1:0]        status,
  input  logic [WORD_W-1:0] out_arg0,
  input  logic [WORD_W-1:0] out_arg1,
  input  logic [WORD_W-1:0] out_arg2,
  input  logic [WORD_W-1:0] out_arg3,
  input  logic [WORD_W-1:0] out_ret0,
  input  logic [WORD_W-1:0] out_ret1,
  input  logic [WORD_W-1:0] out_sync,
  input  logic              queue_is_empty,
  input  logic              wake,
  output int                mismatches,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] arg0;
    logic [WORD_W-1:0] arg1;
    logic [WORD_W-1:0] arg2;
    logic [WORD_W-1:0] arg3;
    logic [WORD_W-1:0] ret0;
    logic [WORD_W-1:0] ret1;
    logic [WORD_W-1:0] sync;
  } message_t;

  typedef struct packed {
    logic [1:0] status;
    message_t   msg;
    logic       empty;
    logic       wake;
  } reply_t;

  localparam logic [PTR_W-1:0] DEPTH_LIMIT = PTR_W'(QUEUE_DEPTH - 1);

  logic [PTR_W-1:0] head_ptr [NUM_QUEUES];
  logic [PTR_W-1:0] tail_ptr [NUM_QUEUES];
  logic [PTR_W-1:0] cap_mask [NUM_QUEUES];
  message_t         slot_mem [NUM_QUEUES][QUEUE_DEPTH];
  reply_t           replies_due[$];

  function automatic reply_t mailbox_step(input logic [1:0] cmd, input logic [2:0] q,
                                          input message_t m, input logic [PTR_W-1:0] mask_in,
                                          input logic waiting);
    reply_t           r;
    logic [PTR_W-1:0] nxt;
    r = '0;
    if (int'(q) >= NUM_QUEUES) begin
      r.status = (cmd == CMD_PUSH) ? STAT_FULL : (cmd == CMD_POP) ? STAT_EMPTY : STAT_OK;
      r.empty  = 1'b1;
      return r;
    end
    case (cmd)
      CMD_PUSH: begin
        nxt = (tail_ptr[q] + 1'b1) & cap_mask[q];
        if (nxt == head_ptr[q]) begin
          r.status = STAT_FULL;
        end else begin
          slot_mem[q][int'(tail_ptr[q]) % QUEUE_DEPTH] = m;
          tail_ptr[q] = nxt;
          r.wake = waiting;
        end
      end
      CMD_POP: begin
        if (head_ptr[q] == tail_ptr[q]) begin
          r.status = STAT_EMPTY;
        end else begin
          r.msg = slot_mem[q][int'(head_ptr[q]) % QUEUE_DEPTH];
          head_ptr[q] = (head_ptr[q] + 1'b1) & cap_mask[q];
        end
      end
      CMD_INIT: begin
        head_ptr[q] = '0;
        tail_ptr[q] = '0;
        cap_mask[q] = mask_in & DEPTH_LIMIT;
      end
      default: begin
      end
    endcase
    r.empty = (head_ptr[q] == tail_ptr[q]);
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [WORD_W-1:0] want,
                                      input logic [WORD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    message_t m;
    reply_t   due;
    if (rst) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_ptr[q] = '0;
        tail_ptr[q] = '0;
        cap_mask[q] = PTR_W'(63) & DEPTH_LIMIT;
      end
      replies_due.delete();
      mismatches = 0;
    end else begin
      if (start && !busy) begin
        m = '{arg_word0, arg_word1, arg_word2, arg_word3, ret_word0, ret_word1, sync_value};
        replies_due.push_back(mailbox_step(command, queue_id, m, new_mask, dest_waiting));
      end
      if (done) begin
        if (replies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with no command outstanding", $time);
        end else begin
          due = replies_due.pop_front();
          check_field("status", WORD_W'(due.status), WORD_W'(status));
          check_field("out_arg0", due.msg.arg0, out_arg0);
          check_field("out_arg1", due.msg.arg1, out_arg1);
          check_field("out_arg2", due.msg.arg2, out_arg2);
          check_field("out_arg3", due.msg.arg3, out_arg3);
          check_field("out_ret0", due.msg.ret0, out_ret0);
          check_field("out_ret1", due.msg.ret1, out_ret1);
          check_field("out_sync", due.msg.sync, out_sync);
          check_field("queue_is_empty", WORD_W'(due.empty), WORD_W'(queue_is_empty));
          check_field("wake", WORD_W'(due.wake), WORD_W'(wake));
        end
      end
    end
    outstanding = replies_due.size();
  end

endmodule

[sim/multi_queue_message_mailbox_unit_tb.sv]
// Testbench top for the multi-queue message mailbox: clock, reset, command stimulus and verdict.
// Depends on mqmb_pkg, multi_queue_message_mailbox_unit and mqmb_mailbox_checker.
module multi_queue_message_mailbox_unit_tb;
  import mqmb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_WORDS = 1150;
  localparam int WORDS_RANDOM = 0;
  localparam int WORDS_ONES   = 1;
  localparam int WORDS_ZERO   = 2;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              done;
  logic [1:0]        command = CMD_QUERY;
  logic [2:0]        queue_id = '0;
  logic [WORD_W-1:0] arg_word0 = '0;
  logic [WORD_W-1:0] arg_word1 = '0;
  logic [WORD_W-1:0] arg_word2 = '0;
  logic [WORD_W-1:0] arg_word3 = '0;
  logic [WORD_W-1:0] ret_word0 = '0;
  logic [WORD_W-1:0] ret_word1 = '0;
  logic [WORD_W-1:0] sync_value = '0;
  logic [PTR_W-1:0]  new_mask = '0;
  logic              dest_waiting = 1'b0;
  logic [1:0]        status;
  logic [WORD_W-1:0] out_arg0;
  logic [WORD_W-1:0] out_arg1;
  logic [WORD_W-1:0] out_arg2;
  logic [WORD_W-1:0] out_arg3;
  logic [WORD_W-1:0] out_ret0;
  logic [WORD_W-1:0] out_ret1;
  logic [WORD_W-1:0] out_sync;
  logic              queue_is_empty;
  logic              wake;
  int                mismatches;
  int                outstanding;

  int               sent = 0;
  bit               calm = 1'b0;
  logic [PTR_W-1:0] mask_now [8];

  always #5 clk = ~clk;

  multi_queue_message_mailbox_unit i_dut (.*);

  mqmb_mailbox_checker i_checker (.*);

  function automatic logic [WORD_W-1:0] msg_word(input int mode);
    if (mode == WORDS_ONES) return '1;
    if (mode == WORDS_ZERO) return '0;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PTR_W-1:0] pick_mask();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 7) return '1;
    if (r >= 8) return PTR_W'($urandom_range(0, 63));
    return PTR_W'((1 << $urandom_range(1, 6)) - 1);
  endfunction

  task automatic pause();
    int r;
    int gap;
    r = $urandom_range(0, 99);
    gap = 0;
    if (!calm) begin
      if (r >= 93) gap = $urandom_range(8, 40);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [2:0] q,
                       input logic [PTR_W-1:0] mask_in, input logic waiting,
                       input int mode = WORDS_RANDOM);
    command      = cmd;
    queue_id     = q;
    arg_word0    = msg_word(mode);
    arg_word1    = msg_word(mode);
    arg_word2    = msg_word(mode);
    arg_word3    = msg_word(mode);
    ret_word0    = msg_word(mode);
    ret_word1    = msg_word(mode);
    sync_value   = msg_word(mode);
    new_mask     = mask_in;
    dest_waiting = waiting;
    start        = 1'b1;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (cmd == CMD_INIT) mask_now[q] = mask_in;
    sent++;
    pause();
  endtask

  task automatic random_command(input logic [2:0] q);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) issue(CMD_PUSH, q, PTR_W'($urandom), 1'($urandom));
    else if (r < 75) issue(CMD_POP, q, PTR_W'($urandom), 1'($urandom));
    else if (r < 87) issue(CMD_QUERY, q, PTR_W'($urandom), 1'($urandom));
    else issue(CMD_INIT, q, pick_mask(), 1'($urandom));
  endtask

  initial begin
    #5_000_000;
    $display("multi_queue_message_mailbox_unit verification failed");
    $finish;
  end

  initial begin
    logic [2:0] q;
    int         n;
    for (int i = 0; i < 8; i++) mask_now[i] = '1;
    repeat (11) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    issue(CMD_POP, 3'd0, '0, 1'b0);
    issue(CMD_QUERY, 3'd0, '0, 1'b0);
    issue(CMD_PUSH, 3'd0, '1, 1'b1, WORDS_ONES);
    issue(CMD_PUSH, 3'd0, '0, 1'b0, WORDS_ZERO);
    issue(CMD_QUERY, 3'd0, '0, 1'b1);
    issue(CMD_POP, 3'd0, '0, 1'b0);
    issue(CMD_POP, 3'd0, '0, 1'b0);
    issue(CMD_POP, 3'd0, '0, 1'b0);
    issue(CMD_INIT, 3'd1, '0, 1'b0);
    issue(CMD_PUSH, 3'd1, '0, 1'b1);
    issue(CMD_POP, 3'd1, '0, 1'b0);
    issue(CMD_QUERY, 3'd1, '0, 1'b0);
    issue(CMD_INIT, 3'd2, 6'd1, 1'b0);
    issue(CMD_PUSH, 3'd2, '0, 1'b1);
    issue(CMD_PUSH, 3'd2, '0, 1'b1);
    issue(CMD_POP, 3'd2, '0, 1'b0);
    issue(CMD_POP, 3'd2, '0, 1'b0);
    issue(CMD_INIT, 3'd3, 6'd2, 1'b0);
    issue(CMD_PUSH, 3'd3, '0, 1'b1);
    issue(CMD_POP, 3'd3, '0, 1'b0);
    issue(CMD_INIT, 3'd7, '1, 1'b1);
    issue(CMD_PUSH, 3'd7, '1, 1'b1, WORDS_ONES);
    issue(CMD_POP, 3'd7, '0, 1'b0);
    issue(CMD_QUERY, 3'd7, '0, 1'b0);

    while (sent < TOTAL_WORDS) begin
      q = 3'($urandom_range(0, 7));
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if ($urandom_range(0, 1)) issue(CMD_INIT, q, pick_mask(), 1'b0);
          n = $urandom_range(1, int'(mask_now[q]) + 2);
          repeat (n) begin
            if ($urandom_range(0, 9) == 0) issue(CMD_QUERY, q, '0, 1'($urandom));
            else issue(CMD_PUSH, q, PTR_W'($urandom), 1'($urandom));
          end
          repeat ($urandom_range(1, n + 1)) issue(CMD_POP, q, PTR_W'($urandom), 1'($urandom));
        end
        5, 6, 7: begin
          repeat ($urandom_range(10, 20)) random_command(3'($urandom_range(0, 7)));
        end
        default: begin
          repeat ($urandom_range(10, 30)) begin
            issue(CMD_PUSH, q, PTR_W'($urandom), 1'($urandom));
            issue(CMD_POP, q, PTR_W'($urandom), 1'($urandom));
          end
        end
      endcase
    end
    calm = 1'b0;
    start = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("multi_queue_message_mailbox_unit verification clean");
    end else begin
      $display("multi_queue_message_mailbox_unit verification failed");
    end
    $finish;
  end

endmodule
